[rtl/pwft_pkg.sv]
// types, codes and constants shared by the wire-format field tokenizer
`default_nettype none
package pwft_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCountWidth = $clog2(QueueDepth + 1);
   localparam int unsigned LastVarintIndex = 9;

   typedef enum logic [2:0] {
      PH_TAG     = 3'd0,
      PH_VALUE   = 3'd1,
      PH_LEN     = 3'd2,
      PH_SKIP    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_FIELD   = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_OK      = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_TRUNCATED = 3'd1,
      ERR_WIRE_TYPE = 3'd2,
      ERR_FIELD_0   = 3'd3,
      ERR_TOO_LONG  = 3'd4
   } error_type;

   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LEN     = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] field_number;
      logic [2:0]  wire_type;
      logic [63:0] field_value;
      logic [7:0]  payload_byte;
      logic [2:0]  error_code;
      logic        run_end;
   } rsp_word_type;

endpackage
`default_nettype wire

[rtl/protobuf_wire_field_tokenizer.sv]
// Protobuf wire-format field tokenizer: one message byte per word in, field, payload,
// message-ok and error words out. An accepted byte is held in an input register and
// decoded from it, once the queue has room for two, into up to two result words, which
// enter a four-word output queue; a new byte is taken every cycle while the queue has
// room for two words. The sustained rate is one byte per cycle while rsp_stall is low,
// limited by the single result word leaving per cycle when a byte gives two results (a
// field or payload word followed by message ok, or a payload word followed by an error).
`default_nettype none
module protobuf_wire_field_tokenizer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire pwft_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pwft_pkg::rsp_word_type     rsp_word
);
   import pwft_pkg::*;

   req_word_type hold_ff;
   logic         hold_valid_ff, hold_valid_in;
   logic         proc;

   phase_type    phase_ff, phase_in;
   logic [63:0]  acc_ff, acc_in;
   logic [3:0]   sc_ff, sc_in;
   logic [31:0]  field_ff, field_in;
   logic [2:0]   type_ff, type_in;
   logic [63:0]  rem_ff, rem_in;
   logic         err_ff, err_in;

   rsp_word_type                queue_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [QueueCountWidth-1:0]  count_ff, count_in;

   logic [5:0]   sh_amt;
   logic [63:0]  acc_new;
   logic         vi_complete, vi_too_long;
   logic [63:0]  rem_dec;

   error_type    fail;
   logic         field_done;
   logic         emit_field, emit_payload;
   logic [63:0]  field_val;

   rsp_word_type tok_word, tail_word, r0, r1;
   logic         has_tok, has_tail;
   logic [1:0]   push_n;
   logic         pop;

   // varint byte decode
   always_comb begin
      sh_amt      = {2'b00, sc_ff} * 6'd7;
      acc_new     = acc_ff | ({57'd0, hold_ff.data_byte[6:0]} << sh_amt);
      vi_complete = !hold_ff.data_byte[7];
      vi_too_long = hold_ff.data_byte[7] && (sc_ff >= 4'(LastVarintIndex));
      rem_dec     = (rem_ff != 64'd0) ? rem_ff - 64'd1 : 64'd0;
   end

   assign proc = hold_valid_ff && (count_ff <= QueueCountWidth'(QueueDepth - 2));

   // next state
   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      sc_in        = sc_ff;
      field_in     = field_ff;
      type_in      = type_ff;
      rem_in       = rem_ff;
      err_in       = err_ff;
      fail         = ERR_NONE;
      field_done   = 1'b0;
      emit_field   = 1'b0;
      emit_payload = 1'b0;
      field_val    = 64'd0;
      if (proc && err_ff) begin
         if (hold_ff.final_byte) begin
            phase_in = PH_TAG;
            acc_in   = 64'd0;
            sc_in    = 4'd0;
            field_in = 32'd0;
            type_in  = 3'd0;
            rem_in   = 64'd0;
            err_in   = 1'b0;
         end
      end else if (proc) begin
         case (phase_ff)
            PH_VALUE, PH_LEN: begin
               acc_in = acc_new;
               if (vi_too_long) begin
                  fail = ERR_TOO_LONG;
               end else if (!vi_complete) begin
                  sc_in = sc_ff + 4'd1;
                  if (hold_ff.final_byte) fail = ERR_TRUNCATED;
               end else begin
                  acc_in = 64'd0;
                  sc_in  = 4'd0;
                  if (phase_ff == PH_VALUE || acc_new == 64'd0) begin
                     emit_field = 1'b1;
                     field_val  = acc_new;
                     phase_in   = PH_TAG;
                     field_done = 1'b1;
                  end else if (hold_ff.final_byte) begin
                     fail = ERR_TRUNCATED;
                  end else begin
                     emit_field = 1'b1;
                     field_val  = acc_new;
                     rem_in     = acc_new;
                     phase_in   = PH_PAYLOAD;
                  end
               end
            end
            PH_SKIP, PH_PAYLOAD: begin
               emit_payload = (phase_ff == PH_PAYLOAD);
               rem_in       = rem_dec;
               if (rem_dec == 64'd0) begin
                  emit_field = (phase_ff == PH_SKIP);
                  phase_in   = PH_TAG;
                  field_done = 1'b1;
               end else if (hold_ff.final_byte) begin
                  fail = ERR_TRUNCATED;
               end
            end
            default: begin
               phase_in = PH_TAG;
               acc_in   = acc_new;
               if (vi_too_long) begin
                  fail = ERR_TOO_LONG;
               end else if (!vi_complete) begin
                  sc_in = sc_ff + 4'd1;
                  if (hold_ff.final_byte) fail = ERR_TRUNCATED;
               end else begin
                  acc_in   = 64'd0;
                  sc_in    = 4'd0;
                  field_in = acc_new[34:3];
                  type_in  = acc_new[2:0];
                  if (acc_new[34:3] == 32'd0) begin
                     fail = ERR_FIELD_0;
                  end else if (acc_new[2:0] == WT_VARINT || acc_new[2:0] == WT_LEN) begin
                     phase_in = (acc_new[2:0] == WT_VARINT) ? PH_VALUE : PH_LEN;
                     if (hold_ff.final_byte) fail = ERR_TRUNCATED;
                  end else if (acc_new[2:0] == WT_FIXED64 || acc_new[2:0] == WT_FIXED32) begin
                     rem_in   = (acc_new[2:0] == WT_FIXED64) ? 64'd8 : 64'd4;
                     phase_in = PH_SKIP;
                     if (hold_ff.final_byte) fail = ERR_TRUNCATED;
                  end else begin
                     fail = ERR_WIRE_TYPE;
                  end
               end
            end
         endcase
         if (fail != ERR_NONE || (hold_ff.final_byte && field_done)) begin
            phase_in = PH_TAG;
            acc_in   = 64'd0;
            sc_in    = 4'd0;
            field_in = 32'd0;
            type_in  = 3'd0;
            rem_in   = 64'd0;
            err_in   = (fail != ERR_NONE) && !hold_ff.final_byte;
         end
      end
   end

   // result words
   always_comb begin
      tok_word              = '0;
      tok_word.kind         = emit_payload ? KIND_PAYLOAD : KIND_FIELD;
      tok_word.field_number = field_ff;
      tok_word.wire_type    = type_ff;
      tok_word.field_value  = field_val;
      tok_word.payload_byte = emit_payload ? hold_ff.data_byte : 8'd0;
      tail_word             = '0;
      tail_word.kind        = (fail != ERR_NONE) ? KIND_ERROR : KIND_OK;
      tail_word.error_code  = fail;
      tail_word.run_end     = 1'b1;
      has_tok  = proc && !err_ff && (emit_field || emit_payload);
      has_tail = proc && !err_ff &&
                 ((fail != ERR_NONE) || (hold_ff.final_byte && field_done));
      tok_word.run_end = !has_tail;
      r0     = has_tok ? tok_word : tail_word;
      r1     = tail_word;
      push_n = {1'b0, has_tok} + {1'b0, has_tail};
   end

   // output queue
   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = queue_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = hold_valid_ff && !proc;

   always_comb begin
      wr_in    = wr_ff + QueuePtrWidth'(push_n);
      rd_in    = rd_ff + QueuePtrWidth'(pop);
      count_in = count_ff + QueueCountWidth'(push_n) - QueueCountWidth'(pop);
      hold_valid_in = hold_valid_ff;
      if (req_valid && !req_stall) begin
         hold_valid_in = 1'b1;
      end else if (proc) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) hold_ff <= req_word;
      if (push_n != 2'd0) queue_ff[wr_ff] <= r0;
      if (push_n == 2'd2) queue_ff[wr_ff + QueuePtrWidth'(1)] <= r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= PH_TAG;
         acc_ff        <= 64'd0;
         sc_ff         <= 4'd0;
         field_ff      <= 32'd0;
         type_ff       <= 3'd0;
         rem_ff        <= 64'd0;
         err_ff        <= 1'b0;
         wr_ff         <= '0;
         rd_ff         <= '0;
         count_ff      <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         sc_ff         <= sc_in;
         field_ff      <= field_in;
         type_ff       <= type_in;
         rem_ff        <= rem_in;
         err_ff        <= err_in;
         wr_ff         <= wr_in;
         rd_ff         <= rd_in;
         count_ff      <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCountWidth'(QueueDepth))
      else $error("result queue overfilled");

   a_drop_after_error: assert property (@(posedge clock) disable iff (reset)
      (proc && err_ff) |-> (push_n == 2'd0))
      else $error("result produced while dropping a failed message");

   a_run_end_last: assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd2) |-> (!r0.run_end && r1.run_end))
      else $error("run_end not on the last result of a byte");

   a_error_latched: assert property (@(posedge clock) disable iff (reset)
      (proc && !err_ff && fail != ERR_NONE && !hold_ff.final_byte) |=> err_ff)
      else $error("error mid-message not remembered");
`endif

endmodule
`default_nettype wire

[bench/tb_protobuf_wire_field_tokenizer.sv]
// testbench for the protobuf wire-format field tokenizer: directed and random messages against a token predictor
`timescale 1ns / 1ps
module tb_protobuf_wire_field_tokenizer;
   import pwft_pkg::*;

   localparam int PhaseItems = 482;
   localparam int QuietLimit = 2000;
   localparam int DrainCycles = 8;

   typedef enum int {VARINT_MORE, VARINT_DONE, VARINT_OVERRUN} varint_step_type;

   class token_scoreboard;
      rsp_word_type expected_tokens[$];
      int errors;
      phase_type phase;
      logic [63:0] acc;
      logic [3:0] shift_cnt;
      logic [31:0] cur_field;
      logic [2:0] cur_type;
      logic [63:0] remaining;
      bit dropping;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase = PH_TAG;
         acc = '0;
         shift_cnt = '0;
         cur_field = '0;
         cur_type = '0;
         remaining = '0;
         dropping = 1'b0;
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      function varint_step_type take_varint(logic [7:0] b);
         int sh;
         sh = 7 * (shift_cnt % 10);
         acc = acc | ({57'd0, b[6:0]} << sh);
         if (!b[7]) return VARINT_DONE;
         if (shift_cnt >= LastVarintIndex) return VARINT_OVERRUN;
         shift_cnt++;
         return VARINT_MORE;
      endfunction

      function rsp_word_type make_word(kind_type k, logic [31:0] fn, logic [2:0] wt,
                                       logic [63:0] val, logic [7:0] pb, error_type err);
         rsp_word_type w;
         w.kind = k;
         w.field_number = fn;
         w.wire_type = wt;
         w.field_value = val;
         w.payload_byte = pb;
         w.error_code = err;
         w.run_end = 1'b0;
         return w;
      endfunction

      function void note_byte(req_word_type word);
         rsp_word_type made[$];
         rsp_word_type w;
         logic [7:0] b;
         logic fin;
         error_type fail;
         bit field_done;
         varint_step_type r;
         logic [63:0] len;
         b = word.data_byte;
         fin = word.final_byte;
         fail = ERR_NONE;
         field_done = 1'b0;
         if (dropping) begin
            if (fin) clear_state();
            return;
         end
         case (phase)
            PH_VALUE: begin
               r = take_varint(b);
               if (r == VARINT_OVERRUN) fail = ERR_TOO_LONG;
               else if (r == VARINT_MORE) begin
                  if (fin) fail = ERR_TRUNCATED;
               end else begin
                  made.insert(made.size(), make_word(KIND_FIELD, cur_field, cur_type, acc,
                                                     8'd0, ERR_NONE));
                  acc = '0;
                  shift_cnt = '0;
                  phase = PH_TAG;
                  field_done = 1'b1;
               end
            end
            PH_LEN: begin
               r = take_varint(b);
               if (r == VARINT_OVERRUN) fail = ERR_TOO_LONG;
               else if (r == VARINT_MORE) begin
                  if (fin) fail = ERR_TRUNCATED;
               end else begin
                  len = acc;
                  acc = '0;
                  shift_cnt = '0;
                  if (len == 0) begin
                     made.insert(made.size(), make_word(KIND_FIELD, cur_field, cur_type,
                                                        64'd0, 8'd0, ERR_NONE));
                     phase = PH_TAG;
                     field_done = 1'b1;
                  end else if (fin) begin
                     fail = ERR_TRUNCATED;
                  end else begin
                     made.insert(made.size(), make_word(KIND_FIELD, cur_field, cur_type,
                                                        len, 8'd0, ERR_NONE));
                     remaining = len;
                     phase = PH_PAYLOAD;
                  end
               end
            end
            PH_SKIP: begin
               if (remaining != 0) remaining--;
               if (remaining == 0) begin
                  made.insert(made.size(), make_word(KIND_FIELD, cur_field, cur_type,
                                                     64'd0, 8'd0, ERR_NONE));
                  phase = PH_TAG;
                  field_done = 1'b1;
               end else if (fin) begin
                  fail = ERR_TRUNCATED;
               end
            end
            PH_PAYLOAD: begin
               made.insert(made.size(), make_word(KIND_PAYLOAD, cur_field, cur_type,
                                                  64'd0, b, ERR_NONE));
               if (remaining != 0) remaining--;
               if (remaining == 0) begin
                  phase = PH_TAG;
                  field_done = 1'b1;
               end else if (fin) begin
                  fail = ERR_TRUNCATED;
               end
            end
            default: begin
               phase = PH_TAG;
               r = take_varint(b);
               if (r == VARINT_OVERRUN) fail = ERR_TOO_LONG;
               else if (r == VARINT_MORE) begin
                  if (fin) fail = ERR_TRUNCATED;
               end else begin
                  cur_field = acc[34:3];
                  cur_type = acc[2:0];
                  acc = '0;
                  shift_cnt = '0;
                  if (cur_field == 0) begin
                     fail = ERR_FIELD_0;
                  end else if (cur_type == WT_VARINT || cur_type == WT_LEN) begin
                     phase = (cur_type == WT_VARINT) ? PH_VALUE : PH_LEN;
                     if (fin) fail = ERR_TRUNCATED;
                  end else if (cur_type == WT_FIXED64 || cur_type == WT_FIXED32) begin
                     remaining = (cur_type == WT_FIXED64) ? 64'd8 : 64'd4;
                     phase = PH_SKIP;
                     if (fin) fail = ERR_TRUNCATED;
                  end else begin
                     fail = ERR_WIRE_TYPE;
                  end
               end
            end
         endcase
         if (fail != ERR_NONE) begin
            made.insert(made.size(), make_word(KIND_ERROR, 32'd0, 3'd0, 64'd0, 8'd0, fail));
            clear_state();
            if (!fin) dropping = 1'b1;
         end else if (fin && field_done) begin
            made.insert(made.size(), make_word(KIND_OK, 32'd0, 3'd0, 64'd0, 8'd0,
                                               ERR_NONE));
            clear_state();
         end
         foreach (made[i]) begin
            w = made[i];
            w.run_end = (i == made.size() - 1);
            expected_tokens.insert(expected_tokens.size(), w);
         end
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_tokens.size() == 0) begin
            $error("unexpected result word: kind %0d", got.kind);
            errors++;
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("field_number", want.field_number, got.field_number);
         compare_field("wire_type", want.wire_type, got.wire_type);
         compare_field("field_value", want.field_value, got.field_value);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("run_end", want.run_end, got.run_end);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   token_scoreboard tokens;
   logic [7:0] msg[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   protobuf_wire_field_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tokens.note_byte(req_word);
         if (rsp_valid && !rsp_stall) tokens.check_word(rsp_word);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("tb_protobuf_wire_field_tokenizer: errors");
            $finish;
         end
      end
   end

   function automatic void add_byte(logic [7:0] b);
      msg.insert(msg.size(), b);
   endfunction

   function automatic void put_varint(logic [63:0] v);
      while (v > 64'd127) begin
         add_byte({1'b1, v[6:0]});
         v = v >> 7;
      end
      add_byte({1'b0, v[6:0]});
   endfunction

   function automatic void put_raw_varint(int n);
      logic [7:0] r;
      bit ones;
      ones = ($urandom_range(7) == 0);
      for (int i = 0; i < n; i++) begin
         r = ones ? 8'hff : 8'($urandom_range(255));
         add_byte({i < n - 1, r[6:0]});
      end
   endfunction

   function automatic void put_random_bytes(int n);
      repeat (n) add_byte(8'($urandom_range(255)));
   endfunction

   function automatic void put_tag(logic [31:0] fn, logic [2:0] wt, logic [28:0] hi);
      put_varint({hi, fn, wt});
   endfunction

   function automatic logic [2:0] pick_type(bit legal);
      logic [2:0] wt;
      do wt = 3'($urandom_range(7));
      while ((wt == WT_VARINT || wt == WT_FIXED64 || wt == WT_LEN || wt == WT_FIXED32)
             != legal);
      return wt;
   endfunction

   function automatic logic [31:0] pick_field();
      logic [31:0] fn;
      case ($urandom_range(3))
         0, 1: fn = 32'($urandom_range(1, 15));
         2: fn = 32'($urandom_range(16, 2047));
         default: fn = $urandom;
      endcase
      if (fn == 0) fn = 32'd1;
      return fn;
   endfunction

   function automatic logic [28:0] pick_high();
      return ($urandom_range(19) == 0) ? 29'($urandom_range(1, 536870911)) : 29'd0;
   endfunction

   function automatic void put_field();
      logic [2:0] wt;
      logic [63:0] len;
      wt = pick_type(1'b1);
      put_tag(pick_field(), wt, pick_high());
      if (wt == WT_VARINT) begin
         if ($urandom_range(1) == 0) put_varint({$urandom, $urandom} >> $urandom_range(63));
         else put_raw_varint($urandom_range(1, 10));
      end else if (wt == WT_LEN) begin
         len = ($urandom_range(9) == 0) ? 64'($urandom_range(6, 20))
                                        : 64'($urandom_range(0, 5));
         put_varint(len);
         put_random_bytes(int'(len));
      end else begin
         put_random_bytes((wt == WT_FIXED64) ? 8 : 4);
      end
   endfunction

   // builds one message into msg and returns the number of its bytes that the block decodes
   function automatic int build_message();
      int sel;
      int start;
      int keep;
      int counted;
      sel = $urandom_range(99);
      if (sel >= 93) begin
         put_random_bytes($urandom_range(1, 12));
         return msg.size();
      end
      repeat ((sel < 60) ? $urandom_range(1, 4) : $urandom_range(0, 2)) put_field();
      if (sel < 60) return msg.size();
      if (sel < 70) begin
         start = msg.size();
         put_field();
         keep = $urandom_range(1, msg.size() - start - 1);
         while (msg.size() > start + keep) void'(msg.pop_back());
         return msg.size();
      end
      if (sel < 78) begin
         put_tag(pick_field(), pick_type(1'b0), pick_high());
      end else if (sel < 85) begin
         put_tag(32'd0, 3'($urandom_range(7)), pick_high());
      end else begin
         case ($urandom_range(2))
            1: put_tag(pick_field(), WT_VARINT, 29'd0);
            2: put_tag(pick_field(), WT_LEN, 29'd0);
            default: ;
         endcase
         repeat (10) add_byte({1'b1, 7'($urandom_range(127))});
      end
      counted = msg.size();
      put_random_bytes($urandom_range(0, 3));
      return counted;
   endfunction

   task automatic send_msg();
      for (int i = 0; i < msg.size(); i++) begin
         while ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_word <= '{data_byte: msg[i], final_byte: (i == msg.size() - 1)};
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      msg.delete();
   endtask

   task automatic run_directed();
      put_tag(32'd1, WT_VARINT, 29'd0);
      put_varint(64'd0);
      send_msg();
      put_tag(32'd2, WT_LEN, 29'd0);
      put_varint(64'd0);
      send_msg();
      put_tag(32'd3, WT_LEN, 29'd0);
      put_varint(64'd1);
      add_byte(8'hff);
      send_msg();
      put_tag(32'd0, WT_VARINT, 29'd0);
      send_msg();
      put_tag(32'd15, pick_type(1'b0), 29'd0);
      send_msg();
      put_tag(32'd1, WT_VARINT, 29'd0);
      send_msg();
      put_tag(32'd4, WT_LEN, 29'd0);
      put_varint(64'd2);
      add_byte(8'h00);
      send_msg();
      put_tag(32'd2, pick_type(1'b0), 29'd0);
      add_byte(8'h00);
      add_byte(8'hff);
      send_msg();
      put_tag(32'd5, WT_VARINT, 29'd1);
      put_varint(64'd1);
      send_msg();
   endtask

   initial begin
      int idle_plan[4];
      int stall_plan[4];
      int decoded;
      idle_plan = '{0, 53, 0, 26};
      stall_plan = '{0, 0, 53, 26};
      tokens = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < 4; p++) begin
         idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         decoded = 0;
         while (decoded < PhaseItems) begin
            decoded += build_message();
            send_msg();
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (tokens.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (tokens.errors == 0) $display("tb_protobuf_wire_field_tokenizer: clean");
      else $display("tb_protobuf_wire_field_tokenizer: errors");
      $finish;
   end

endmodule

[protobuf_wire_field_tokenizer.f]
rtl/pwft_pkg.sv
rtl/protobuf_wire_field_tokenizer.sv
bench/tb_protobuf_wire_field_tokenizer.sv
